// ----- src/h2r_pkg.sv -----
// shared types and constants for the hsl to rgb converter
`default_nettype none
package h2r_pkg;

  // field widths
  localparam int HUE_W = 15;
  localparam int CH_W  = 8;

  // internal widths
  localparam int M_W   = 16;   // m1, m2 and their difference, units of 1/255^2
  localparam int T_W   = 12;   // position inside a ramp, 0..HUE_SEC
  localparam int NUM_W = 28;   // channel numerator plus rounding offset
  localparam int Y_W   = 20;   // numerator with the power-of-two factor removed
  localparam int PR_W  = 29;   // reciprocal product
  localparam int Q_W   = 9;    // quotient before saturation

  localparam int NUM_STAGES = 5;

  // hue geometry in 1/64 degree
  localparam logic [HUE_W-1:0] HUE_SEC   = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_SEC3  = 15'd11520;
  localparam logic [HUE_W-1:0] HUE_SEC4  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_THIRD = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // divide by 255 * 3840 = 2^8 * 3825
  localparam logic [NUM_W-1:0] HALF_DEN       = 28'd489600;
  localparam int               DIV_PRE_SHIFT  = 8;
  localparam logic [Y_W-1:0]   DIV_RES        = 20'd3825;
  localparam logic [PR_W-1:0]  RECIP_K        = 29'd274;
  localparam int               RECIP_SHIFT    = 20;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_en_t;

  typedef struct packed {
    logic [M_W-1:0] m1;
    logic [M_W-1:0] diff;
    logic [T_W-1:0] t;
  } chan_op_t;

endpackage
`default_nettype wire

// ----- src/h2r_in_if.sv -----
// pixel input channel: hue, saturation, lightness and alpha
`default_nettype none
interface h2r_in_if;
  import h2r_pkg::*;

  logic            valid;
  logic            ready;
  logic [HUE_W-1:0] hue_angle;
  logic [CH_W-1:0]  sat_level;
  logic [CH_W-1:0]  light_level;
  logic [CH_W-1:0]  alpha_in;

  modport source (
    output valid, hue_angle, sat_level, light_level, alpha_in,
    input  ready
  );

  modport sink (
    input  valid, hue_angle, sat_level, light_level, alpha_in,
    output ready
  );

endinterface
`default_nettype wire

// ----- src/h2r_out_if.sv -----
// pixel output channel: red, green, blue and alpha
`default_nettype none
interface h2r_out_if;
  import h2r_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic [CH_W-1:0] alpha_out;

  modport source (
    output valid, red_out, green_out, blue_out, alpha_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, alpha_out,
    output ready
  );

endinterface
`default_nettype wire

// ----- src/h2r_front.sv -----
// stages one and two: hue wrap and offsets, m1/m2 and ramp positions
`default_nettype none
module h2r_front (
  input  wire logic                          clk,
  input  wire h2r_pkg::pipe_en_t             stg,
  input  wire logic [h2r_pkg::HUE_W-1:0]     hue_angle,
  input  wire logic [h2r_pkg::CH_W-1:0]      sat_level,
  input  wire logic [h2r_pkg::CH_W-1:0]      light_level,
  output h2r_pkg::chan_op_t                  op_red,
  output h2r_pkg::chan_op_t                  op_green,
  output h2r_pkg::chan_op_t                  op_blue
);
  import h2r_pkg::*;

  function automatic logic [T_W-1:0] ramp_pos(input logic [HUE_W-1:0] h);
    logic [HUE_W-1:0] fall;
    fall = HUE_SEC4 - h;
    priority if (h < HUE_SEC) begin
      return h[T_W-1:0];
    end else if (h < HUE_SEC3) begin
      return HUE_SEC[T_W-1:0];
    end else if (h < HUE_SEC4) begin
      return fall[T_W-1:0];
    end else begin
      return '0;
    end
  endfunction

  // stage one
  logic [HUE_W-1:0] h_wrap;
  logic [HUE_W-1:0] hr_nxt, hg_nxt, hb_nxt;
  logic [M_W-1:0]   prod_nxt;
  logic [HUE_W-1:0] hr_r, hg_r, hb_r;
  logic [M_W-1:0]   prod_r;
  logic [CH_W-1:0]  l_r, s_r;

  always_comb begin
    h_wrap = (hue_angle >= HUE_FULL) ? hue_angle - HUE_FULL : hue_angle;
    hg_nxt = h_wrap;
    hr_nxt = (h_wrap >= HUE_FULL - HUE_THIRD) ? h_wrap - (HUE_FULL - HUE_THIRD)
                                              : h_wrap + HUE_THIRD;
    hb_nxt = (h_wrap < HUE_THIRD) ? h_wrap + (HUE_FULL - HUE_THIRD)
                                  : h_wrap - HUE_THIRD;
    prod_nxt = M_W'(light_level) * M_W'(sat_level);
  end

  always_ff @(posedge clk) begin
    if (stg.en[0]) begin
      hr_r   <= hr_nxt;
      hg_r   <= hg_nxt;
      hb_r   <= hb_nxt;
      prod_r <= prod_nxt;
      l_r    <= light_level;
      s_r    <= sat_level;
    end
  end

  // stage two
  logic [M_W+1:0]  l255, ls255, twol255;
  logic [M_W+1:0]  m2_wide, m1_wide;
  logic [M_W-1:0]  m1_nxt, diff_nxt;
  chan_op_t        op_red_r, op_green_r, op_blue_r;

  always_comb begin
    l255    = (18'(l_r) << 8) - 18'(l_r);
    ls255   = ((18'(l_r) + 18'(s_r)) << 8) - (18'(l_r) + 18'(s_r));
    twol255 = l255 << 1;
    // lower formula up to and including half lightness
    if (!l_r[CH_W-1]) begin
      m2_wide = l255 + 18'(prod_r);
    end else begin
      m2_wide = ls255 - 18'(prod_r);
    end
    m1_wide  = twol255 - m2_wide;
    m1_nxt   = m1_wide[M_W-1:0];
    diff_nxt = m2_wide[M_W-1:0] - m1_wide[M_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (stg.en[1]) begin
      op_red_r   <= '{m1: m1_nxt, diff: diff_nxt, t: ramp_pos(hr_r)};
      op_green_r <= '{m1: m1_nxt, diff: diff_nxt, t: ramp_pos(hg_r)};
      op_blue_r  <= '{m1: m1_nxt, diff: diff_nxt, t: ramp_pos(hb_r)};
    end
  end

  assign op_red   = op_red_r;
  assign op_green = op_green_r;
  assign op_blue  = op_blue_r;

endmodule
`default_nettype wire

// ----- src/h2r_chan.sv -----
// stages three to five for one channel: numerator, reciprocal divide, saturation
`default_nettype none
module h2r_chan (
  input  wire logic                      clk,
  input  wire h2r_pkg::pipe_en_t         stg,
  input  wire h2r_pkg::chan_op_t         op,
  output logic [h2r_pkg::CH_W-1:0]       level
);
  import h2r_pkg::*;

  // stage three: m1 * sector + diff * t + half the divisor
  logic [NUM_W-1:0] x_nxt, x_r;

  assign x_nxt = NUM_W'(op.m1) * NUM_W'(HUE_SEC) + NUM_W'(op.diff) * NUM_W'(op.t) + HALF_DEN;

  always_ff @(posedge clk) begin
    if (stg.en[2]) begin
      x_r <= x_nxt;
    end
  end

  // stage four: estimate quotient, low by at most one
  logic [Y_W-1:0]  y_nxt, y_r;
  logic [PR_W-1:0] pr;
  logic [Q_W-1:0]  q0_nxt, q0_r;

  always_comb begin
    y_nxt  = x_r[NUM_W-1:DIV_PRE_SHIFT];
    pr     = PR_W'(y_nxt) * RECIP_K;
    q0_nxt = pr[PR_W-1:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (stg.en[3]) begin
      y_r  <= y_nxt;
      q0_r <= q0_nxt;
    end
  end

  // stage five: correct and saturate
  logic [Y_W-1:0]  qm, rem;
  logic [Q_W-1:0]  q;
  logic [CH_W-1:0] level_nxt, level_r;

  always_comb begin
    qm  = Y_W'(q0_r) * DIV_RES;
    rem = y_r - qm;
    q   = q0_r + Q_W'(rem >= DIV_RES);
    level_nxt = (q > Q_W'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (stg.en[4]) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule
`default_nettype wire

// ----- src/hsl_to_rgb_converter_top.sv -----
// hsl to rgb converter: five-stage pipeline, one pixel per clock
// each pixel passes stages one to five in order; out_pix.valid is the stage five valid bit
// throughput: one transaction per cycle; each stage holds while the next is full
// and stalled, and bubbles close up, so nothing is lost or repeated
// reset: rst_n clears the stage valid bits only; data registers are not reset
`default_nettype none
module hsl_to_rgb_converter_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  h2r_in_if.sink      in_pix,
  h2r_out_if.source   out_pix
);
  import h2r_pkg::*;

  logic [NUM_STAGES-1:0] v_r, v_nxt;
  logic [NUM_STAGES-1:0] rdy;
  pipe_en_t              stg;
  logic [CH_W-1:0]       alpha_r [NUM_STAGES];

  // a stage loads when empty or when the stage after it moves on
  always_comb begin
    rdy[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_pix.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    stg.en = rdy;
    v_nxt[0] = in_pix.valid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      alpha_r[0] <= in_pix.alpha_in;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        alpha_r[k] <= alpha_r[k-1];
      end
    end
  end

  chan_op_t op_red, op_green, op_blue;

  h2r_front u_front (
    .clk         (clk),
    .stg         (stg),
    .hue_angle   (in_pix.hue_angle),
    .sat_level   (in_pix.sat_level),
    .light_level (in_pix.light_level),
    .op_red      (op_red),
    .op_green    (op_green),
    .op_blue     (op_blue)
  );

  logic [CH_W-1:0] red_lvl, green_lvl, blue_lvl;

  h2r_chan u_red (
    .clk   (clk),
    .stg   (stg),
    .op    (op_red),
    .level (red_lvl)
  );

  h2r_chan u_green (
    .clk   (clk),
    .stg   (stg),
    .op    (op_green),
    .level (green_lvl)
  );

  h2r_chan u_blue (
    .clk   (clk),
    .stg   (stg),
    .op    (op_blue),
    .level (blue_lvl)
  );

  assign in_pix.ready      = rdy[0];
  assign out_pix.valid     = v_r[NUM_STAGES-1];
  assign out_pix.red_out   = red_lvl;
  assign out_pix.green_out = green_lvl;
  assign out_pix.blue_out  = blue_lvl;
  assign out_pix.alpha_out = alpha_r[NUM_STAGES-1];

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// testbench for the hsl to rgb converter: directed and random pixels, scoreboard
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import h2r_pkg::HUE_W;
  import h2r_pkg::CH_W;

  localparam int SECTOR_UNITS = 3840;
  localparam int THIRD_UNITS  = 7680;
  localparam int CIRCLE_UNITS = 23040;
  localparam int FULL_SCALE   = 255;
  localparam int RANDOM_PIXELS = 1800;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int CALM_START    = 1500;
  localparam int CALM_END      = 2500;
  localparam int HOLD_AFTER    = 900;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 12;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  light;
    logic [CH_W-1:0]  alpha;
  } hsla_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

  logic clk = 1'b0;
  logic rst_n;

  h2r_in_if  in_bus ();
  h2r_out_if out_bus ();

  hsl_to_rgb_converter_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_bus),
    .out_pix (out_bus)
  );

  always #4 clk = ~clk;

  hsla_t pending_pixels[$];
  rgba_t expected_colors[$];
  hsla_t offered_pixel;
  int    total_pixels;
  int    accepted_count;
  int    results_seen;
  int    mismatch_count;
  int    cycle_count;
  int    hold_left;
  bit    hold_done;

  // one channel: ramp up, plateau, ramp down, floor
  function automatic int unsigned ramp_level(int unsigned h, longint unsigned m1,
                                             longint unsigned m2);
    longint unsigned pos;
    longint unsigned num;
    longint unsigned den;
    longint unsigned r;
    den = FULL_SCALE * SECTOR_UNITS;
    if (h < SECTOR_UNITS) begin
      pos = h;
    end else if (h < 3 * SECTOR_UNITS) begin
      pos = SECTOR_UNITS;
    end else if (h < 4 * SECTOR_UNITS) begin
      pos = 4 * SECTOR_UNITS - h;
    end else begin
      pos = 0;
    end
    num = m1 * SECTOR_UNITS + (m2 - m1) * pos;
    r = (num + den / 2) / den;
    if (r > FULL_SCALE) r = FULL_SCALE;
    return int'(r);
  endfunction

  function automatic rgba_t convert_pixel(hsla_t px);
    rgba_t           c;
    int unsigned     h;
    longint unsigned s;
    longint unsigned l;
    longint unsigned m1;
    longint unsigned m2;
    h = px.hue % CIRCLE_UNITS;
    s = px.sat;
    l = px.light;
    c.alpha = px.alpha;
    if (s == 0) begin
      c.red   = px.light;
      c.green = px.light;
      c.blue  = px.light;
      return c;
    end
    // half lightness exactly takes the lower formula
    if (2 * l <= FULL_SCALE) begin
      m2 = l * (FULL_SCALE + s);
    end else begin
      m2 = (l + s) * FULL_SCALE - l * s;
    end
    m1 = 2 * l * FULL_SCALE - m2;
    c.red   = CH_W'(ramp_level((h + THIRD_UNITS) % CIRCLE_UNITS, m1, m2));
    c.green = CH_W'(ramp_level(h, m1, m2));
    c.blue  = CH_W'(ramp_level((h + CIRCLE_UNITS - THIRD_UNITS) % CIRCLE_UNITS, m1, m2));
    return c;
  endfunction

  function automatic bit idle_now();
    if (cycle_count >= CALM_START && cycle_count < CALM_END) return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic add_pixel(int hue, int sat, int light, int alpha);
    hsla_t px;
    px.hue   = HUE_W'(hue);
    px.sat   = CH_W'(sat);
    px.light = CH_W'(light);
    px.alpha = CH_W'(alpha);
    pending_pixels.push_back(px);
  endtask

  // cycle counter and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // driver: each accepted transaction gets its prediction queued
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        expected_colors.push_back(convert_pixel(offered_pixel));
        accepted_count++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_pixels.size() > 0 && !idle_now()) begin
          offered_pixel = pending_pixels.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.hue_angle   <= offered_pixel.hue;
          in_bus.sat_level   <= offered_pixel.sat;
          in_bus.light_level <= offered_pixel.light;
          in_bus.alpha_in    <= offered_pixel.alpha;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= (hold_left == 0) && !idle_now();
    end
  end

  // monitor
  always @(posedge clk) begin
    rgba_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("unexpected transaction, red", out_bus.red_out, -1);
      end else begin
        want = expected_colors.pop_front();
        if (out_bus.red_out !== want.red)
          report_mismatch("red", out_bus.red_out, want.red);
        if (out_bus.green_out !== want.green)
          report_mismatch("green", out_bus.green_out, want.green);
        if (out_bus.blue_out !== want.blue)
          report_mismatch("blue", out_bus.blue_out, want.blue);
        if (out_bus.alpha_out !== want.alpha)
          report_mismatch("alpha", out_bus.alpha_out, want.alpha);
      end
      results_seen++;
    end
  end

  initial begin
    int hue;
    int sat;
    int light;
    int pick;
    rst_n = 1'b0;
    cycle_count = 0;
    accepted_count = 0;
    results_seen = 0;
    mismatch_count = 0;
    in_bus.valid = 1'b0;
    in_bus.hue_angle = '0;
    in_bus.sat_level = '0;
    in_bus.light_level = '0;
    in_bus.alpha_in = '0;
    out_bus.ready = 1'b0;

    // grey, primaries, sector edges, half lightness, wrap of the hue
    add_pixel(0, 0, 0, 0);
    add_pixel(0, 0, 255, 255);
    add_pixel(5000, 0, 100, 77);
    add_pixel(0, 255, 127, 255);
    add_pixel(0, 255, 128, 1);
    add_pixel(7680, 255, 64, 128);
    add_pixel(15360, 255, 200, 200);
    add_pixel(3839, 200, 127, 3);
    add_pixel(3840, 200, 128, 4);
    add_pixel(11519, 1, 127, 5);
    add_pixel(11520, 1, 128, 6);
    add_pixel(15359, 128, 255, 7);
    add_pixel(23039, 255, 255, 8);
    add_pixel(23040, 255, 128, 9);
    add_pixel(32767, 255, 127, 10);
    add_pixel(26880, 100, 50, 11);
    add_pixel(0, 1, 1, 254);
    add_pixel(12345, 255, 0, 12);
    add_pixel(1920, 255, 127, 13);
    add_pixel(9600, 77, 191, 14);
    add_pixel(30720, 170, 85, 15);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        hue = $urandom_range(0, CIRCLE_UNITS - 1);
      end else if (pick < 85) begin
        hue = $urandom_range(CIRCLE_UNITS, (1 << HUE_W) - 1);
      end else begin
        // near a sector boundary
        hue = $urandom_range(0, 5) * SECTOR_UNITS + $urandom_range(0, 6) - 3;
        if (hue < 0) hue = hue + CIRCLE_UNITS;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) sat = 0;
      else if (pick < 20) sat = 255;
      else sat = $urandom_range(0, 255);
      pick = $urandom_range(0, 99);
      if (pick < 10) light = $urandom_range(126, 129);
      else if (pick < 15) light = $urandom_range(0, 1) * 255;
      else light = $urandom_range(0, 255);
      add_pixel(hue, sat, light, $urandom_range(0, 255));
    end
    total_pixels = pending_pixels.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_pixels || expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_colors.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
